/* rtl/lav_pkg.sv */
// Shared constants, types and helpers for the look-at view matrix pipeline.
`default_nettype none

package lav_pkg;

   // Fraction bits of every fixed-point value.
   localparam int FRAC_BITS = 16;

   // Signed width of an axis component (holds +/- 2^FRAC_BITS).
   localparam int AW = FRAC_BITS + 2;
   // Quotient bits of a normalized component.
   localparam int QW = FRAC_BITS + 1;
   // Width of a position word and of an output axis field.
   localparam int WW = 32;
   localparam int FW = 18;

   // Normalizer widths.
   localparam int MAGW = WW + 1;
   localparam int SCW = 31;
   localparam int SQW = 2 * SCW;
   localparam int SUMW = 64;
   localparam int RTW = 32;
   localparam int RT_STEPS = SUMW / 2;
   localparam int DW = RTW + FRAC_BITS;

   // Basis and translation widths.
   localparam int PW = 2 * AW;
   localparam int XW = AW + WW + 2;

   // Stage counts.
   localparam int NORM_LAT = RT_STEPS + QW + 7;
   localparam int BASIS_LAT = 3;
   localparam int XLATE_LAT = 4;
   localparam int PIPE_DEPTH = 1 + 2 * NORM_LAT + BASIS_LAT + XLATE_LAT;

   typedef logic signed [AW-1:0] axis_type;
   typedef axis_type vec_type [3];
   typedef logic signed [WW-1:0] word_type;
   typedef word_type word_vec_type [3];

   typedef struct packed {
      logic [2:0][SCW-1:0] m;
      logic [2:0]          neg;
      logic                zero;
   } norm_carry_type;

   // Magnitude of an axis component, widened for the normalizer.
   function automatic logic [MAGW-1:0] axis_mag(input axis_type a);
      logic [AW-1:0] t;
      t = a[AW-1] ? AW'(-a) : AW'(a);
      return MAGW'(t);
   endfunction

   // An axis component placed in its 18-bit output field.
   function automatic logic [FW-1:0] field_of(input axis_type a);
      logic [AW+FW-1:0] t;
      t = {{FW{a[AW-1]}}, a};
      return t[FW-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/lav_norm.sv */
// Pipelined vector normalizer: scaling, square root and division by stages.
`default_nettype none

module lav_norm import lav_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [MAGW-1:0]  mag_in [3],
   input  logic             neg_in [3],
   output vec_type          axis_out
);

   localparam int LZW = $clog2(MAGW);
   localparam int TOP_POS = SCW - 1;

   function automatic logic [LZW-1:0] lead_pos(input logic [MAGW-1:0] x);
      logic [LZW-1:0] p;
      p = '0;
      for (int i = 0; i < MAGW; i++) begin
         if (x[i]) p = LZW'(i);
      end
      return p;
   endfunction

   // Scaling stages.
   logic [MAGW-1:0] mag1_ff [3];
   logic [2:0]      neg1_ff;
   logic [MAGW-1:0] top1_ff, top1_in;
   logic [MAGW-1:0] mag2_ff [3];
   logic [2:0]      neg2_ff;
   logic            zero2_ff;
   logic [LZW-1:0]  rsh2_ff, lsh2_ff, pos2_in;
   norm_carry_type  c3_ff, c4_ff;
   logic [SQW-1:0]  sq4_ff [3];

   // Square root stages.
   logic [SUMW-1:0] n_ff [RT_STEPS+1];
   logic [SUMW-1:0] res_ff [RT_STEPS+1];
   logic [SUMW-1:0] n_in [RT_STEPS];
   logic [SUMW-1:0] res_in [RT_STEPS];
   logic [SUMW-1:0] trial [RT_STEPS];
   norm_carry_type  cs_ff [RT_STEPS+1];

   // Division stages.
   logic [DW-1:0]   rem_ff [QW+1][3];
   logic [QW-1:0]   q_ff [QW+1][3];
   logic [DW-1:0]   rem_in [QW][3];
   logic [QW-1:0]   q_in [QW][3];
   logic [DW-1:0]   dv [QW];
   logic [RTW-1:0]  rt_ff [QW+1];
   norm_carry_type  cd_ff [QW+1];
   logic [RTW-1:0]  root;

   vec_type         axis_ff;

   always_comb begin
      top1_in = mag_in[0];
      if (mag_in[1] > top1_in) top1_in = mag_in[1];
      if (mag_in[2] > top1_in) top1_in = mag_in[2];
   end

   assign pos2_in = lead_pos(top1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= mag_in[i];
            neg1_ff[i] <= neg_in[i];
            mag2_ff[i] <= mag1_ff[i];
         end
         top1_ff <= top1_in;
         neg2_ff <= neg1_ff;
         zero2_ff <= (top1_ff == '0);
         if (pos2_in > LZW'(TOP_POS)) begin
            rsh2_ff <= pos2_in - LZW'(TOP_POS);
            lsh2_ff <= '0;
         end else begin
            rsh2_ff <= '0;
            lsh2_ff <= LZW'(TOP_POS) - pos2_in;
         end
         // All components take the shift that brings the largest into range.
         for (int i = 0; i < 3; i++) begin
            c3_ff.m[i] <= SCW'((mag2_ff[i] >> rsh2_ff) << lsh2_ff);
            sq4_ff[i] <= SQW'(c3_ff.m[i]) * SQW'(c3_ff.m[i]);
         end
         c3_ff.neg <= neg2_ff;
         c3_ff.zero <= zero2_ff;
         c4_ff <= c3_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < RT_STEPS; k++) begin
         trial[k] = res_ff[k] + (SUMW'(1) << (SUMW - 2 - 2 * k));
         if (n_ff[k] >= trial[k]) begin
            n_in[k] = n_ff[k] - trial[k];
            res_in[k] = (res_ff[k] >> 1) + (SUMW'(1) << (SUMW - 2 - 2 * k));
         end else begin
            n_in[k] = n_ff[k];
            res_in[k] = res_ff[k] >> 1;
         end
      end
   end

   assign root = res_ff[RT_STEPS][RTW-1:0];

   always_comb begin
      for (int j = 0; j < QW; j++) begin
         dv[j] = DW'(rt_ff[j]) << (QW - 1 - j);
         for (int i = 0; i < 3; i++) begin
            if (rem_ff[j][i] >= dv[j]) begin
               rem_in[j][i] = rem_ff[j][i] - dv[j];
               q_in[j][i] = q_ff[j][i] | (QW'(1) << (QW - 1 - j));
            end else begin
               rem_in[j][i] = rem_ff[j][i];
               q_in[j][i] = q_ff[j][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0] <= SUMW'(sq4_ff[0]) + SUMW'(sq4_ff[1]) + SUMW'(sq4_ff[2]);
         res_ff[0] <= '0;
         cs_ff[0] <= c4_ff;
         for (int k = 0; k < RT_STEPS; k++) begin
            n_ff[k+1] <= n_in[k];
            res_ff[k+1] <= res_in[k];
            cs_ff[k+1] <= cs_ff[k];
         end
         // Dividend with half the divisor added for round to nearest.
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= (DW'(cs_ff[RT_STEPS].m[i]) << FRAC_BITS) + DW'(root >> 1);
            q_ff[0][i] <= '0;
         end
         rt_ff[0] <= root;
         cd_ff[0] <= cs_ff[RT_STEPS];
         for (int j = 0; j < QW; j++) begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[j+1][i] <= rem_in[j][i];
               q_ff[j+1][i] <= q_in[j][i];
            end
            rt_ff[j+1] <= rt_ff[j];
            cd_ff[j+1] <= cd_ff[j];
         end
         for (int i = 0; i < 3; i++) begin
            if (cd_ff[QW].zero) begin
               axis_ff[i] <= '0;
            end else if (cd_ff[QW].neg[i]) begin
               axis_ff[i] <= -axis_type'({1'b0, q_ff[QW][i]});
            end else begin
               axis_ff[i] <= axis_type'({1'b0, q_ff[QW][i]});
            end
         end
      end
   end

   assign axis_out = axis_ff;

endmodule

`default_nettype wire

/* rtl/lav_basis.sv */
// Up axis as the cross product of the forward and side axes.
`default_nettype none

module lav_basis import lav_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  vec_type fwd_in,
   input  vec_type side_in,
   output vec_type fwd_out,
   output vec_type side_out,
   output vec_type up_out
);

   localparam int SW = PW + 1;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SW-1:0] ONE = SW'(1) <<< FRAC_BITS;

   logic signed [PW-1:0] p_ff [4];
   logic signed [SW-1:0] s_ff [3];
   logic signed [SW-1:0] r_in [3];
   vec_type              up_ff;
   vec_type              fd_ff [BASIS_LAT];
   vec_type              sd_ff [BASIS_LAT];

   // Round to nearest with ties away from zero, then clamp to the unit range.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_in[i] = (s_ff[i] + (s_ff[i] < 0 ? HALF - SW'(1) : HALF)) >>> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= PW'(fwd_in[1]) * PW'(side_in[2]);
         p_ff[1] <= PW'(fwd_in[2]) * PW'(side_in[0]);
         p_ff[2] <= PW'(fwd_in[0]) * PW'(side_in[2]);
         p_ff[3] <= PW'(fwd_in[1]) * PW'(side_in[0]);
         s_ff[0] <= SW'(p_ff[0]);
         s_ff[1] <= SW'(p_ff[1]) - SW'(p_ff[2]);
         s_ff[2] <= -SW'(p_ff[3]);
         for (int i = 0; i < 3; i++) begin
            if (r_in[i] > ONE) begin
               up_ff[i] <= AW'(ONE);
            end else if (r_in[i] < -ONE) begin
               up_ff[i] <= AW'(-ONE);
            end else begin
               up_ff[i] <= AW'(r_in[i]);
            end
         end
         fd_ff[0] <= fwd_in;
         sd_ff[0] <= side_in;
         for (int k = 1; k < BASIS_LAT; k++) begin
            fd_ff[k] <= fd_ff[k-1];
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   assign up_out = up_ff;
   assign fwd_out = fd_ff[BASIS_LAT-1];
   assign side_out = sd_ff[BASIS_LAT-1];

endmodule

`default_nettype wire

/* rtl/lav_xlate.sv */
// Translations: negated, rounded and saturated dot products of the axes with the eye.
`default_nettype none

module lav_xlate import lav_pkg::*; (
   input  logic         clock,
   input  logic         en,
   input  vec_type      side_in,
   input  vec_type      up_in,
   input  vec_type      fwd_in,
   input  word_vec_type eye_in,
   output vec_type      side_out,
   output vec_type      up_out,
   output vec_type      fwd_out,
   output word_vec_type shift_out
);

   localparam logic signed [XW-1:0] HALF = XW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [XW-1:0] WMAX = XW'(2147483647);
   localparam logic signed [XW-1:0] WMIN = -XW'(2147483647) - XW'(1);

   logic signed [XW-1:0] pr_ff [3][3];
   logic signed [XW-1:0] d_ff [3];
   logic signed [XW-1:0] nd_ff [3];
   logic signed [XW-1:0] t_in [3];
   word_vec_type         shift_ff;
   vec_type              sd_ff [XLATE_LAT];
   vec_type              ud_ff [XLATE_LAT];
   vec_type              fd_ff [XLATE_LAT];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         t_in[a] = (nd_ff[a] + (nd_ff[a] < 0 ? HALF - XW'(1) : HALF)) >>> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pr_ff[0][i] <= XW'(side_in[i]) * XW'(eye_in[i]);
            pr_ff[1][i] <= XW'(up_in[i]) * XW'(eye_in[i]);
            pr_ff[2][i] <= XW'(fwd_in[i]) * XW'(eye_in[i]);
         end
         for (int a = 0; a < 3; a++) begin
            d_ff[a] <= pr_ff[a][0] + pr_ff[a][1] + pr_ff[a][2];
            nd_ff[a] <= -d_ff[a];
            if (t_in[a] > WMAX) begin
               shift_ff[a] <= WW'(WMAX);
            end else if (t_in[a] < WMIN) begin
               shift_ff[a] <= WW'(WMIN);
            end else begin
               shift_ff[a] <= WW'(t_in[a]);
            end
         end
         sd_ff[0] <= side_in;
         ud_ff[0] <= up_in;
         fd_ff[0] <= fwd_in;
         for (int k = 1; k < XLATE_LAT; k++) begin
            sd_ff[k] <= sd_ff[k-1];
            ud_ff[k] <= ud_ff[k-1];
            fd_ff[k] <= fd_ff[k-1];
         end
      end
   end

   assign shift_out = shift_ff;
   assign side_out = sd_ff[XLATE_LAT-1];
   assign up_out = ud_ff[XLATE_LAT-1];
   assign fwd_out = fd_ff[XLATE_LAT-1];

endmodule

`default_nettype wire

/* rtl/look_at_view_matrix.sv */
// Look-at view matrix: camera basis and translations from an eye and a target point.
//
// The req channel carries one eye position and one target point, six signed
// Q16.16 words; a transfer happens when req_valid is high and req_stall low.
// The rsp channel returns the side, up and forward axes (18-bit signed Q2.16)
// and the three translations (32-bit signed, saturated) of that pair.
// Two normalizers of FRAC_BITS + 40 stages each, set by the 32-step square
// root and the FRAC_BITS + 1 step division, are followed by the cross
// product and the dot products. One pair enters and one result leaves per
// cycle while the pipeline is not frozen.
// A valid bit travels with each stage. When rsp_stall holds a waiting result,
// the whole pipeline freezes and req_stall rises in the same cycle, so no
// item is lost or repeated. Reset empties the pipeline by clearing its valid
// bits; the data path has no feedback, so results do not depend on earlier pairs.
`default_nettype none

module look_at_view_matrix import lav_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [WW-1:0] req_eye_x,
   input  logic signed [WW-1:0] req_eye_y,
   input  logic signed [WW-1:0] req_eye_z,
   input  logic signed [WW-1:0] req_target_x,
   input  logic signed [WW-1:0] req_target_y,
   input  logic signed [WW-1:0] req_target_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [FW-1:0] rsp_side_x,
   output logic signed [FW-1:0] rsp_side_y,
   output logic signed [FW-1:0] rsp_side_z,
   output logic signed [FW-1:0] rsp_upward_x,
   output logic signed [FW-1:0] rsp_upward_y,
   output logic signed [FW-1:0] rsp_upward_z,
   output logic signed [FW-1:0] rsp_fwd_x,
   output logic signed [FW-1:0] rsp_fwd_y,
   output logic signed [FW-1:0] rsp_fwd_z,
   output logic signed [WW-1:0] rsp_shift_u,
   output logic signed [WW-1:0] rsp_shift_v,
   output logic signed [WW-1:0] rsp_shift_w
);

   localparam int EYE_DLY = 2 * NORM_LAT + BASIS_LAT + 1;

   logic                    en;
   logic [PIPE_DEPTH-1:0]   vld_ff;
   word_vec_type            eye_in, tgt_in;
   logic signed [MAGW-1:0]  dir_in [3];
   logic [MAGW-1:0]         dmag_ff [3];
   logic                    dneg_ff [3];
   word_vec_type            eye_ff [EYE_DLY];
   vec_type                 w_axis, u_axis;
   vec_type                 wd_ff [NORM_LAT];
   logic [MAGW-1:0]         smag [3];
   logic                    sneg [3];
   vec_type                 b_fwd, b_side, b_up;
   vec_type                 o_side, o_up, o_fwd;
   word_vec_type            o_shift;

   // The whole pipeline moves unless a finished result is being held.
   assign en = !vld_ff[PIPE_DEPTH-1] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   assign eye_in[0] = req_eye_x;
   assign eye_in[1] = req_eye_y;
   assign eye_in[2] = req_eye_z;
   assign tgt_in[0] = req_target_x;
   assign tgt_in[1] = req_target_y;
   assign tgt_in[2] = req_target_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dir_in[i] = MAGW'(tgt_in[i]) - MAGW'(eye_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dneg_ff[i] <= dir_in[i][MAGW-1];
            dmag_ff[i] <= dir_in[i][MAGW-1] ? MAGW'(-dir_in[i]) : MAGW'(dir_in[i]);
         end
         eye_ff[0] <= eye_in;
         for (int k = 1; k < EYE_DLY; k++) begin
            eye_ff[k] <= eye_ff[k-1];
         end
         wd_ff[0] <= w_axis;
         for (int k = 1; k < NORM_LAT; k++) begin
            wd_ff[k] <= wd_ff[k-1];
         end
      end
   end

   lav_norm u_norm_fwd (
      .clock    (clock),
      .en       (en),
      .mag_in   (dmag_ff),
      .neg_in   (dneg_ff),
      .axis_out (w_axis)
   );

   // Side axis input is (-w.z, 0, w.x).
   always_comb begin
      smag[0] = axis_mag(w_axis[2]);
      sneg[0] = (w_axis[2] > 0);
      smag[1] = '0;
      sneg[1] = 1'b0;
      smag[2] = axis_mag(w_axis[0]);
      sneg[2] = w_axis[0][AW-1];
   end

   lav_norm u_norm_side (
      .clock    (clock),
      .en       (en),
      .mag_in   (smag),
      .neg_in   (sneg),
      .axis_out (u_axis)
   );

   lav_basis u_basis (
      .clock    (clock),
      .en       (en),
      .fwd_in   (wd_ff[NORM_LAT-1]),
      .side_in  (u_axis),
      .fwd_out  (b_fwd),
      .side_out (b_side),
      .up_out   (b_up)
   );

   lav_xlate u_xlate (
      .clock     (clock),
      .en        (en),
      .side_in   (b_side),
      .up_in     (b_up),
      .fwd_in    (b_fwd),
      .eye_in    (eye_ff[EYE_DLY-1]),
      .side_out  (o_side),
      .up_out    (o_up),
      .fwd_out   (o_fwd),
      .shift_out (o_shift)
   );

   assign rsp_side_x = field_of(o_side[0]);
   assign rsp_side_y = field_of(o_side[1]);
   assign rsp_side_z = field_of(o_side[2]);
   assign rsp_upward_x = field_of(o_up[0]);
   assign rsp_upward_y = field_of(o_up[1]);
   assign rsp_upward_z = field_of(o_up[2]);
   assign rsp_fwd_x = field_of(o_fwd[0]);
   assign rsp_fwd_y = field_of(o_fwd[1]);
   assign rsp_fwd_z = field_of(o_fwd[2]);
   assign rsp_shift_u = o_shift[0];
   assign rsp_shift_v = o_shift[1];
   assign rsp_shift_w = o_shift[2];

endmodule

`default_nettype wire

/* rtl/lav_check.sv */
// Port-level checks for the look-at view matrix, bound to the top level.
`default_nettype none

module lav_check import lav_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic signed [FW-1:0] rsp_side_x,
   input logic signed [FW-1:0] rsp_side_y,
   input logic signed [FW-1:0] rsp_side_z,
   input logic signed [FW-1:0] rsp_upward_x,
   input logic signed [FW-1:0] rsp_upward_y,
   input logic signed [FW-1:0] rsp_upward_z,
   input logic signed [FW-1:0] rsp_fwd_x,
   input logic signed [FW-1:0] rsp_fwd_y,
   input logic signed [FW-1:0] rsp_fwd_z,
   input logic signed [WW-1:0] rsp_shift_u,
   input logic signed [WW-1:0] rsp_shift_v,
   input logic signed [WW-1:0] rsp_shift_w
);

   // Reset empties the pipeline, so no transfer is offered right after it.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_shift_u)
         && $stable(rsp_shift_v) && $stable(rsp_shift_w) && $stable(rsp_fwd_x))
      else $error("stalled result changed");

   // The side axis never has a vertical component.
   a_side_flat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_side_y == '0)
      else $error("side axis has a vertical component");

   // A zero forward axis forces the whole basis and every translation to zero.
   a_zero_view: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fwd_x == '0 && rsp_fwd_y == '0 && rsp_fwd_z == '0
      |-> rsp_side_x == '0 && rsp_side_z == '0 && rsp_upward_x == '0
         && rsp_upward_y == '0 && rsp_upward_z == '0 && rsp_shift_u == '0
         && rsp_shift_v == '0 && rsp_shift_w == '0)
      else $error("zero view produced a nonzero basis or translation");

endmodule

bind look_at_view_matrix lav_check u_lav_check (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_side_x   (rsp_side_x),
   .rsp_side_y   (rsp_side_y),
   .rsp_side_z   (rsp_side_z),
   .rsp_upward_x (rsp_upward_x),
   .rsp_upward_y (rsp_upward_y),
   .rsp_upward_z (rsp_upward_z),
   .rsp_fwd_x    (rsp_fwd_x),
   .rsp_fwd_y    (rsp_fwd_y),
   .rsp_fwd_z    (rsp_fwd_z),
   .rsp_shift_u  (rsp_shift_u),
   .rsp_shift_v  (rsp_shift_v),
   .rsp_shift_w  (rsp_shift_w)
);

`default_nettype wire

/* dv/tb_look_at_view_matrix.sv */
// Testbench for the look-at view matrix: directed and random camera pairs checked against a predictor.
`timescale 1ns / 1ps

module tb_look_at_view_matrix import lav_pkg::*; ();

   localparam int LATENCY = 2 * (FRAC_BITS + 40) + 8;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_PAIRS = 1450;

   typedef struct packed {
      logic [8:0][FW-1:0] axes;
      logic [2:0][WW-1:0] shifts;
   } view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [WW-1:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic signed [WW-1:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [FW-1:0] rsp_side_x, rsp_side_y, rsp_side_z;
   logic signed [FW-1:0] rsp_upward_x, rsp_upward_y, rsp_upward_z;
   logic signed [FW-1:0] rsp_fwd_x, rsp_fwd_y, rsp_fwd_z;
   logic signed [WW-1:0] rsp_shift_u, rsp_shift_v, rsp_shift_w;

   view_type pending_views[$];
   int mismatches = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   look_at_view_matrix dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint unsigned mag_of(input longint x);
      return x < 0 ? longint'(0) - x : x;
   endfunction

   function automatic longint round_frac(input longint x);
      longint unsigned m;
      m = (mag_of(x) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return x < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic void unit_vector(input longint a[3], output longint r[3]);
      longint unsigned m[3], top, sum, root, q;
      top = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = mag_of(a[i]);
         if (m[i] > top) top = m[i];
      end
      if (top == 0) begin
         for (int i = 0; i < 3; i++) r[i] = 0;
         return;
      end
      // Bring the largest magnitude into [2^30, 2^31) before the square root.
      while (top >= (64'd1 << 31)) begin
         top = top >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (top < (64'd1 << 30)) begin
         top = top << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      root = root_floor(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FRAC_BITS) + (root >> 1)) / root;
         r[i] = a[i] < 0 ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic longint clamp_one(input longint x);
      longint one;
      one = longint'(1) << FRAC_BITS;
      return x > one ? one : (x < -one ? -one : x);
   endfunction

   function automatic logic [WW-1:0] shift_of(input longint ax[3], input longint eye[3]);
      longint t;
      t = round_frac(-(ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2]));
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return t[WW-1:0];
   endfunction

   function automatic view_type predict_view(input logic signed [WW-1:0] ex, ey, ez,
                                             input logic signed [WW-1:0] tx, ty, tz);
      longint eye[3], dir[3], w[3], side_in[3], u[3], v[3];
      view_type res;
      eye[0] = ex; eye[1] = ey; eye[2] = ez;
      dir[0] = longint'(tx) - eye[0];
      dir[1] = longint'(ty) - eye[1];
      dir[2] = longint'(tz) - eye[2];
      unit_vector(dir, w);
      side_in[0] = -w[2];
      side_in[1] = 0;
      side_in[2] = w[0];
      unit_vector(side_in, u);
      v[0] = clamp_one(round_frac(w[1] * u[2]));
      v[1] = clamp_one(round_frac(w[2] * u[0] - w[0] * u[2]));
      v[2] = clamp_one(round_frac(-(w[1] * u[0])));
      for (int i = 0; i < 3; i++) begin
         res.axes[8 - i] = u[i][FW-1:0];
         res.axes[5 - i] = v[i][FW-1:0];
         res.axes[2 - i] = w[i][FW-1:0];
      end
      res.shifts[2] = shift_of(u, eye);
      res.shifts[1] = shift_of(v, eye);
      res.shifts[0] = shift_of(w, eye);
      return res;
   endfunction

   task automatic send_pair(input logic signed [WW-1:0] ex, ey, ez, tx, ty, tz);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_eye_x <= ex; req_eye_y <= ey; req_eye_z <= ez;
      req_target_x <= tx; req_target_y <= ty; req_target_z <= tz;
      do @(posedge clock); while (req_stall);
      pending_views.push_back(predict_view(ex, ey, ez, tx, ty, tz));
   endtask

   function automatic logic [WW-1:0] pick_word(input int kind);
      case (kind)
         0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
         default: return $urandom;
      endcase
   endfunction

   // Extremes of the position words and axis-aligned views.
   task automatic test_extremes();
      logic signed [WW-1:0] top, bot;
      top = 32'h7FFF_FFFF;
      bot = 32'h8000_0000;
      send_pair(bot, bot, bot, top, top, top);
      send_pair(top, top, top, bot, bot, bot);
      send_pair(bot, 0, top, top, 0, bot);
      send_pair(0, 0, 0, 32'h0001_0000, 0, 0);
      send_pair(0, 0, 0, -32'sh0001_0000, 0, 0);
      send_pair(0, 0, 0, 0, 0, 32'h0001_0000);
      send_pair(0, 0, 0, 0, 0, -32'sh0001_0000);
      send_pair(0, 0, 0, 1, 0, 1);
      send_pair(top, bot, top, bot, top, bot);
      send_pair(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1, 1, 1);
      send_pair(-1, -1, -1, 0, 0, 0);
      send_pair(32'h1234_5678, -32'sh0765_4321, 32'h7000_0000, -32'sh7000_0000, 5, 9);
   endtask

   // Eye on the target, and views straight up or down.
   task automatic test_degenerate_views();
      send_pair(0, 0, 0, 0, 0, 0);
      send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h55AA_55AA,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h55AA_55AA);
      send_pair(5, 0, 7, 5, 32'h0001_0000, 7);
      send_pair(5, 0, 7, 5, -32'sh0001_0000, 7);
      send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_pair(-32'sh4000_0000, 32'h7FFF_FFFF, 32'h4000_0000,
                -32'sh4000_0000, 32'h8000_0000, 32'h4000_0000);
   endtask

   task automatic test_random_pairs();
      logic signed [WW-1:0] e[3], t[3];
      int kind, shape;
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         if (n == RANDOM_PAIRS - 250) calm = 1'b1;
         shape = $urandom_range(0, 9);
         kind = shape < 6 ? 2 : (shape < 8 ? 1 : 0);
         if (shape == 9) kind = $urandom_range(0, 2);
         for (int i = 0; i < 3; i++) begin
            e[i] = pick_word(kind);
            t[i] = pick_word(kind);
         end
         // Some pairs share the eye, or look straight along y.
         if ($urandom_range(0, 15) == 0) t = e;
         else if ($urandom_range(0, 15) == 0) begin
            t[0] = e[0];
            t[2] = e[2];
         end
         send_pair(e[0], e[1], e[2], t[0], t[1], t[2]);
      end
   endtask

   always @(posedge clock) begin
      view_type got, want;
      got.axes = {rsp_side_x, rsp_side_y, rsp_side_z, rsp_upward_x, rsp_upward_y,
                  rsp_upward_z, rsp_fwd_x, rsp_fwd_y, rsp_fwd_z};
      got.shifts = {rsp_shift_u, rsp_shift_v, rsp_shift_w};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_views.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer at %0t", $time);
         end else begin
            want = pending_views.pop_front();
            for (int i = 0; i < 9; i++)
               if (got.axes[i] !== want.axes[i]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("axis field %0d: expected %h, got %h", 8 - i,
                              want.axes[i], got.axes[i]);
               end
            for (int i = 0; i < 3; i++)
               if (got.shifts[i] !== want.shifts[i]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("shift field %0d: expected %h, got %h", 2 - i,
                              want.shifts[i], got.shifts[i]);
               end
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 18);
      end
      rsp_stall <= !calm && (stall_left > 1 || (stall_left == 0 && 1'b0)) ? 1'b1 :
                   (!calm && stall_left == 1);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_degenerate_views();
      test_random_pairs();
      req_valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && pending_views.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
